@@ design/shc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shc_pkg
// shared types, constants and helpers for the sequence hash combiner
// ----------------------------------------------------------------------------
package shc_pkg;

    localparam logic [63:0] PRIME_ONE      = 64'd11400714785074694791;
    localparam logic [63:0] PRIME_TWO      = 64'd14029467366897019727;
    localparam logic [63:0] PRIME_FIVE     = 64'd2870177450012600261;
    localparam logic [63:0] LENGTH_MANGLE  = 64'd3527539;
    localparam logic [63:0] ALL_ONES_SUBST = 64'd1546275796;
    localparam logic [63:0] FINAL_XOR      = PRIME_FIVE ^ LENGTH_MANGLE;

    // input item
    typedef struct packed {
        logic [63:0] lane_hash;
        logic        last_lane;
        logic        empty_sequence;
    } t_in;

    // result item
    typedef struct packed {
        logic [63:0] hash_value;
        logic        hash_error;
    } t_out;

    // which 32 x 32 partial product the shared multiplier forms
    typedef enum logic [1:0] {
        PART_LL,
        PART_LH,
        PART_HL
    } t_mul_part;

    // what the product register does this cycle
    typedef enum logic [1:0] {
        PROD_HOLD,
        PROD_LOAD,
        PROD_ADD_HI
    } t_prod_op;

    typedef struct packed {
        logic      load;
        t_mul_part part;
        logic      use_p1;
        t_prod_op  prod_op;
        logic      mix;
        logic      store;
        logic      finish;
    } t_cmd;

    typedef struct packed {
        logic err;
        logic last;
        logic empty;
        logic out_free;
    } t_status;

    function automatic logic [63:0] rotl31(input logic [63:0] x);
        return {x[32:0], x[63:33]};
    endfunction

endpackage

@@ design/shc_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shc_datapath
// accumulator, lane count, shared 32 x 32 multiplier and result register
// ----------------------------------------------------------------------------
module shc_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  shc_pkg::t_in   i_in_data,
    input  shc_pkg::t_cmd  i_cmd,
    input  logic           i_out_ready,
    output shc_pkg::t_status o_status,
    output logic           o_out_valid,
    output shc_pkg::t_out  o_out_data
);

    logic [63:0] r_acc;
    logic [63:0] r_count;
    logic        r_err;
    logic [63:0] r_x;
    logic        r_last;
    logic        r_empty;
    logic [63:0] r_pp;
    logic [63:0] r_prod;
    logic        r_out_valid;
    shc_pkg::t_out r_out;

    logic [63:0] w_const;
    logic [31:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic [63:0] w_final;
    logic        w_out_free;

    assign w_const = i_cmd.use_p1 ? shc_pkg::PRIME_ONE : shc_pkg::PRIME_TWO;

    always_comb begin
        unique case (i_cmd.part)
            shc_pkg::PART_LL: begin
                w_mul_a = r_x[31:0];
                w_mul_b = w_const[31:0];
            end
            shc_pkg::PART_LH: begin
                w_mul_a = r_x[31:0];
                w_mul_b = w_const[63:32];
            end
            shc_pkg::PART_HL: begin
                w_mul_a = r_x[63:32];
                w_mul_b = w_const[31:0];
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_final    = r_acc + (r_count ^ shc_pkg::FINAL_XOR);
    assign w_out_free = !r_out_valid || i_out_ready;

    // multiplier, product accumulation, lane capture, mixing and result value
    always_ff @(posedge i_clk) begin
        r_pp <= 64'(w_mul_a) * 64'(w_mul_b);
        unique case (i_cmd.prod_op)
            shc_pkg::PROD_LOAD:   r_prod <= r_pp;
            shc_pkg::PROD_ADD_HI: r_prod <= r_prod + {r_pp[31:0], 32'd0};
            default:              r_prod <= r_prod;
        endcase
        if (i_cmd.load) begin
            r_x     <= i_in_data.lane_hash;
            r_last  <= i_in_data.last_lane;
            r_empty <= i_in_data.empty_sequence;
        end else if (i_cmd.mix) begin
            r_x <= shc_pkg::rotl31(r_acc + r_prod);
        end
        if (i_cmd.finish) begin
            if (r_err) begin
                r_out.hash_value <= '1;
                r_out.hash_error <= 1'b1;
            end else begin
                r_out.hash_value <= (w_final == '1) ? shc_pkg::ALL_ONES_SUBST : w_final;
                r_out.hash_error <= 1'b0;
            end
        end
    end

    // sequence state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= shc_pkg::PRIME_FIVE;
            r_count     <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load && !i_in_data.empty_sequence) begin
                r_count <= r_count + 64'd1;
                if (i_in_data.lane_hash == '1) begin
                    r_err <= 1'b1;
                end
            end
            if (i_cmd.store) begin
                r_acc <= r_prod;
            end
            if (i_cmd.finish) begin
                r_acc       <= shc_pkg::PRIME_FIVE;
                r_count     <= '0;
                r_err       <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.err      = r_err;
    assign o_status.last     = r_last;
    assign o_status.empty    = r_empty;
    assign o_status.out_free = w_out_free;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

endmodule

@@ design/shc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shc_ctrl
// sequencer for the two lane multiplications, mixing and finishing
// ----------------------------------------------------------------------------
module shc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  shc_pkg::t_status i_status,
    output logic             o_in_ready,
    output shc_pkg::t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_M1_LL,
        ST_M1_LH,
        ST_M1_HL,
        ST_M1_SUM,
        ST_MIX,
        ST_M2_LL,
        ST_M2_LH,
        ST_M2_HL,
        ST_M2_SUM,
        ST_STORE,
        ST_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd         = '0;
        o_cmd.part    = shc_pkg::PART_LL;
        o_cmd.prod_op = shc_pkg::PROD_HOLD;
        n_state       = r_state;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_M1_LL;
                end
            end
            ST_M1_LL: begin
                // item decoded here, after capture
                priority if (i_status.empty) begin
                    n_state = ST_FINISH;
                end else if (i_status.err) begin
                    n_state = i_status.last ? ST_FINISH : ST_IDLE;
                end else begin
                    n_state = ST_M1_LH;
                end
            end
            ST_M1_LH: begin
                o_cmd.part    = shc_pkg::PART_LH;
                o_cmd.prod_op = shc_pkg::PROD_LOAD;
                n_state       = ST_M1_HL;
            end
            ST_M1_HL: begin
                o_cmd.part    = shc_pkg::PART_HL;
                o_cmd.prod_op = shc_pkg::PROD_ADD_HI;
                n_state       = ST_M1_SUM;
            end
            ST_M1_SUM: begin
                o_cmd.prod_op = shc_pkg::PROD_ADD_HI;
                n_state       = ST_MIX;
            end
            ST_MIX: begin
                o_cmd.mix = 1'b1;
                n_state   = ST_M2_LL;
            end
            ST_M2_LL: begin
                o_cmd.use_p1 = 1'b1;
                n_state      = ST_M2_LH;
            end
            ST_M2_LH: begin
                o_cmd.use_p1  = 1'b1;
                o_cmd.part    = shc_pkg::PART_LH;
                o_cmd.prod_op = shc_pkg::PROD_LOAD;
                n_state       = ST_M2_HL;
            end
            ST_M2_HL: begin
                o_cmd.use_p1  = 1'b1;
                o_cmd.part    = shc_pkg::PART_HL;
                o_cmd.prod_op = shc_pkg::PROD_ADD_HI;
                n_state       = ST_M2_SUM;
            end
            ST_M2_SUM: begin
                o_cmd.prod_op = shc_pkg::PROD_ADD_HI;
                n_state       = ST_STORE;
            end
            ST_STORE: begin
                o_cmd.store = 1'b1;
                n_state     = i_status.last ? ST_FINISH : ST_IDLE;
            end
            ST_FINISH: begin
                o_cmd.finish = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

@@ design/sequence_hash_combiner_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_hash_combiner_core
// folds a stream of 64-bit element hashes into one sequence hash
// ----------------------------------------------------------------------------
// usage
//   input channel: one element hash per transfer, last_lane closes the
//   sequence; a transfer with empty_sequence set closes it with no lane
//   output channel: one result per closed sequence (hash_value, hash_error)
// operation
//   each lane goes through two 64 x 64 constant multiplications, each built
//   from three 32 x 32 partial products on one shared multiplier; the block
//   is not ready while a lane passes decode, both multiplications, the mix
//   and the store, plus the finish state when it closes the sequence; a
//   lane after an error is only counted: decode, plus finish when closing;
//   an empty marker takes decode and finish; results are registered at finish
// reset
//   synchronous active-low; the accumulator returns to prime 5, the count
//   and error flag clear and no result is pending
// back-pressure
//   the result sits in an output register, so a further item is taken while
//   it waits; the block only stalls when it must finish a sequence and the
//   output register is still full
// ----------------------------------------------------------------------------
module sequence_hash_combiner_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  shc_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output shc_pkg::t_out o_out_data
);

    shc_pkg::t_cmd    w_cmd;
    shc_pkg::t_status w_status;

    // controller: sequences partial products, mixing and finishing
    shc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    // datapath: accumulator, count, multiplier and output register
    shc_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .i_out_ready (i_out_ready),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // one transfer in, then not ready in the next cycle
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken on consecutive cycles");

    // an error result always carries the all-ones hash
    a_error_all_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.hash_error) |-> (o_out_data.hash_value == '1))
        else $error("error result without all-ones hash");

    // a good result never shows the all-ones pattern
    a_no_all_ones_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.hash_error) |-> (o_out_data.hash_value != '1))
        else $error("all-ones hash not substituted");

    // reset leaves the block ready with nothing pending
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_in_ready && !o_out_valid))
        else $error("bad state after reset");

endmodule

@@ tb/sequence_hash_combiner_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_hash_combiner_core_tb
// self-checking bench for the lane-combining sequence hash core
// ----------------------------------------------------------------------------
// element hashes are pushed through the input channel as directed cases,
// then as random sequences, a back-to-back burst, a long output hold-off and
// a drain pause; an in-bench model of the lane round predicts every
// result, and each output transfer is compared field by field in order
// ----------------------------------------------------------------------------
module sequence_hash_combiner_core_tb;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 6;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int RX_HOLD_LEN   = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int REPORT_LIMIT  = 10;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    shc_pkg::t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    shc_pkg::t_out o_out_data;

    sequence_hash_combiner_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // model state of the combiner
    logic [63:0] hash_accum;
    logic [63:0] lanes_absorbed;
    logic        error_pending;
    shc_pkg::t_out pending_hashes[$];

    // run bookkeeping
    int items_sent = 0;
    int results_seen = 0;
    int error_results = 0;
    int mismatches = 0;
    int input_stalls = 0;
    int cycle_count = 0;

    // idling controls, written only by the test sequence
    bit sender_idle = 1'b1;
    bit receiver_idle = 1'b1;
    int hold_request = 0;

    // ------------------------------------------------------------------------
    // gap lengths: mostly none, some short, a few long
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // lane values biased towards the corners of the 64-bit range
    function automatic logic [63:0] rand_lane();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return {64{1'b1}};
        else if (r < 8)
            return 64'd0;
        else if (r < 12)
            return {32'hffff_ffff, 32'($urandom)};
        else if (r < 15)
            return {32'd0, 32'($urandom)};
        else
            return {32'($urandom), 32'($urandom)};
    endfunction

    // multiplicative inverse modulo 2^64 of an odd constant (newton steps)
    function automatic logic [63:0] mul_inverse(input logic [63:0] a);
        logic [63:0] x;
        x = a;
        repeat (6) x = x * (64'd2 - a * x);
        return x;
    endfunction

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    function automatic void clear_sequence();
        hash_accum     = shc_pkg::PRIME_FIVE;
        lanes_absorbed = 64'd0;
        error_pending  = 1'b0;
    endfunction

    function automatic void close_sequence();
        shc_pkg::t_out res;
        if (error_pending) begin
            res.hash_value = {64{1'b1}};
            res.hash_error = 1'b1;
        end else begin
            res.hash_value = hash_accum + (lanes_absorbed ^ shc_pkg::FINAL_XOR);
            // an all-ones hash is reserved for errors
            if (res.hash_value == {64{1'b1}})
                res.hash_value = shc_pkg::ALL_ONES_SUBST;
            res.hash_error = 1'b0;
        end
        pending_hashes.push_back(res);
        clear_sequence();
    endfunction

    function automatic void absorb_transfer(input shc_pkg::t_in item);
        logic [63:0] mixed;
        if (item.empty_sequence) begin
            // lane and last bits carry no meaning on an empty marker
            close_sequence();
            return;
        end
        if (item.lane_hash == {64{1'b1}})
            error_pending = 1'b1;
        // once an error is seen lanes are only counted
        if (!error_pending) begin
            mixed = hash_accum + item.lane_hash * shc_pkg::PRIME_TWO;
            mixed = {mixed[32:0], mixed[63:33]};
            hash_accum = mixed * shc_pkg::PRIME_ONE;
        end
        lanes_absorbed = lanes_absorbed + 64'd1;
        if (item.last_lane)
            close_sequence();
    endfunction

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------
    task automatic send_item(input shc_pkg::t_in item);
        int gap;
        gap = sender_idle ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        absorb_transfer(item);
        items_sent++;
    endtask

    task automatic send_lane(input logic [63:0] lane, input logic last, input logic empty);
        shc_pkg::t_in item;
        item.lane_hash      = lane;
        item.last_lane      = last;
        item.empty_sequence = empty;
        send_item(item);
    endtask

    // drop valid and wait for every predicted result to come out
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_hashes.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // output side: random ready, plus a long hold-off on request
    // ------------------------------------------------------------------------
    int hold_ack = 0;
    int hold_left = 0;
    int rx_gap = 0;

    always @(posedge i_clk) begin
        if (hold_request != hold_ack) begin
            hold_ack  = hold_request;
            hold_left = RX_HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            i_out_ready <= 1'b0;
        end else begin
            rx_gap = receiver_idle ? pick_gap() : 0;
            i_out_ready <= (rx_gap == 0);
        end
    end

    // result checker: each output transfer against the oldest prediction
    always @(posedge i_clk) begin
        shc_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (o_out_data.hash_error)
                error_results++;
            if (pending_hashes.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: hash %h error %b",
                             o_out_data.hash_value, o_out_data.hash_error);
            end else begin
                want = pending_hashes.pop_front();
                if (o_out_data.hash_value !== want.hash_value ||
                    o_out_data.hash_error !== want.hash_error) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("result %0d mismatch: hash %h error %b, wanted %h error %b",
                                 results_seen, o_out_data.hash_value,
                                 o_out_data.hash_error, want.hash_value,
                                 want.hash_error);
                end
            end
        end
    end

    // stall statistics and the run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (i_rst_n && i_in_valid && !o_in_ready)
            input_stalls++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_hashes.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // corners of the lane field and every special case
    task automatic test_directed();
        logic [63:0] target;
        logic [63:0] pre_mul;
        logic [63:0] lane_sub;
        // empty marker straight from reset, with junk in the ignored fields
        send_lane({64{1'b1}}, 1'b1, 1'b1);
        send_lane(64'd0, 1'b1, 1'b0);
        send_lane({64{1'b1}}, 1'b1, 1'b0);
        send_lane({{63{1'b1}}, 1'b0}, 1'b1, 1'b0);
        // plain multi-lane sequence with alternating bit patterns
        send_lane(64'd1, 1'b0, 1'b0);
        send_lane(64'h8000_0000_0000_0000, 1'b0, 1'b0);
        send_lane(64'h5555_5555_5555_5555, 1'b0, 1'b0);
        send_lane(64'haaaa_aaaa_aaaa_aaaa, 1'b1, 1'b0);
        // failed element mid-sequence, later lanes only counted
        send_lane(64'd7, 1'b0, 1'b0);
        send_lane({64{1'b1}}, 1'b0, 1'b0);
        send_lane(64'd3, 1'b0, 1'b0);
        send_lane(64'd0, 1'b1, 1'b0);
        // empty marker closing an open sequence; its all-ones lane is ignored
        send_lane(64'd9, 1'b0, 1'b0);
        send_lane(64'd10, 1'b0, 1'b0);
        send_lane({64{1'b1}}, 1'b0, 1'b1);
        // single lane chosen so the final sum is all ones: substitute value
        target   = {64{1'b1}} - (64'd1 ^ shc_pkg::FINAL_XOR);
        pre_mul  = target * mul_inverse(shc_pkg::PRIME_ONE);
        pre_mul  = {pre_mul[30:0], pre_mul[63:31]};
        lane_sub = (pre_mul - shc_pkg::PRIME_FIVE) * mul_inverse(shc_pkg::PRIME_TWO);
        send_lane(lane_sub, 1'b1, 1'b0);
        // last and empty together: empty wins, the lane is not absorbed
        send_lane(64'h0123_4567_89ab_cdef, 1'b0, 1'b0);
        send_lane(64'd5, 1'b1, 1'b1);
        // error lane then an empty marker still reports the error
        send_lane({64{1'b1}}, 1'b0, 1'b0);
        send_lane(64'd0, 1'b0, 1'b1);
        wait_drained();
    endtask

    // mostly well-formed sequences, with lone markers and broken ones
    task automatic test_random_sequences(input int n_items);
        int first;
        int kind;
        int len;
        first = items_sent;
        while (items_sent - first < n_items) begin
            kind = $urandom_range(0, 99);
            if (kind < 78) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24)
                                                  : $urandom_range(1, 5);
                for (int k = 0; k < len; k++)
                    send_lane(rand_lane(), k == len - 1, 1'b0);
            end else if (kind < 88) begin
                send_lane(rand_lane(), 1'($urandom_range(0, 1)), 1'b1);
            end else begin
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++)
                    send_lane(rand_lane(), 1'b0, 1'b0);
                send_lane(rand_lane(), 1'($urandom_range(0, 1)), 1'b1);
            end
        end
    endtask

    // no idling on either side
    task automatic test_back_to_back();
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        test_random_sequences(150);
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        wait_drained();
    endtask

    // long output hold-off while short sequences keep coming
    task automatic test_output_hold();
        sender_idle = 1'b0;
        hold_request++;
        for (int k = 0; k < 60; k++)
            send_lane(rand_lane(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 7) == 0));
        sender_idle = 1'b1;
        wait_drained();
    endtask

    // sender pauses until all results are out, then carries on
    task automatic test_drain_pause();
        test_random_sequences(20);
        wait_drained();
        test_random_sequences(20);
        wait_drained();
    endtask

    initial begin
        clear_sequence();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_sequences(1250);
        wait_drained();
        test_back_to_back();
        test_output_hold();
        test_drain_pause();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d input transfers and %0d sequence results, %0d flagged as errors",
                 items_sent, results_seen, error_results);
        $display("input stalled for %0d cycles over %0d cycles, %0d mismatches",
                 input_stalls, cycle_count, mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
